/* rtl/udpcc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// udpcc_pkg
// Shared types and constants for the UDP over IPv4 checksum checker.
// ----------------------------------------------------------------------------
package udpcc_pkg;

    localparam int COUNT_BITS_DEF    = 16;
    localparam int ADDRESS_BYTES_DEF = 4;

    localparam int IHL_BITS      = 6;
    localparam int PROTO_POS     = 9;
    localparam int ADDR_FIRST    = 12;
    localparam int OFF_DST       = 2;
    localparam int OFF_LEN       = 4;
    localparam int OFF_CHK       = 6;
    localparam int UDP_HDR_BYTES = 8;
    localparam int SUM_BITS      = 36;

    typedef enum logic [1:0] {
        ST_GOOD     = 2'd0,
        ST_DISABLED = 2'd1,
        ST_BAD      = 2'd2
    } t_status;

    typedef struct packed {
        logic [31:0] sum;
        logic [7:0]  proto;
        logic [15:0] ip_udp_len;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [15:0] udp_len;
        logic [15:0] rx_chk;
        logic [7:0]  pending;
    } t_snap;

endpackage
`default_nettype wire

/* rtl/udpcc_acc.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// udpcc_acc
// Input register and per-byte header parse and running sum; hands a snapshot
// of the packet state downstream on the last byte and clears for the next.
// ----------------------------------------------------------------------------
module udpcc_acc #(
    parameter int COUNT_BITS    = udpcc_pkg::COUNT_BITS_DEF,
    parameter int ADDRESS_BYTES = udpcc_pkg::ADDRESS_BYTES_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  wire  [7:0]           i_data_byte,
    input  wire                  i_last_byte,
    output logic                 o_snap_valid,
    output udpcc_pkg::t_snap     o_snap,
    input  wire                  i_snap_ready
);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam int ADDR_LAST = udpcc_pkg::ADDR_FIRST + 2 * ADDRESS_BYTES;

    logic                              r_in_valid;
    logic [7:0]                        r_byte;
    logic                              r_last;

    logic [COUNT_BITS-1:0]             r_count, n_count;
    logic [udpcc_pkg::IHL_BITS-1:0]    r_ihl, n_ihl;
    logic [7:0]                        r_proto, n_proto;
    logic [31:0]                       r_sum, n_sum;
    logic [7:0]                        r_pend, n_pend;
    logic [15:0]                       r_len, n_len;
    logic [15:0]                       r_src, n_src;
    logic [15:0]                       r_dst, n_dst;
    logic [15:0]                       r_chk, n_chk;

    logic [COUNT_BITS-1:0]             w_off;
    logic                              w_high;
    logic                              w_take;

    function automatic logic [15:0] set_half(logic [15:0] f, logic [7:0] b, logic hi);
        logic [15:0] v;
        v = hi ? {b, f[7:0]} : {f[15:8], b};
        return v;
    endfunction

    assign w_take       = r_in_valid && (!r_last || i_snap_ready);
    assign o_in_ready   = !r_in_valid || w_take;
    assign o_snap_valid = r_in_valid && r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_byte <= i_data_byte;
            r_last <= i_last_byte;
        end
    end

    always_comb begin
        n_count = r_count;
        n_ihl   = r_ihl;
        n_proto = r_proto;
        n_sum   = r_sum;
        n_pend  = r_pend;
        n_len   = r_len;
        n_src   = r_src;
        n_dst   = r_dst;
        n_chk   = r_chk;
        w_off   = '0;
        w_high  = 1'b0;
        if (r_count != COUNT_MAX) begin
            if (r_count == '0) begin
                n_ihl = {r_byte[3:0], 2'b00};
            end
            if (r_count == COUNT_BITS'(udpcc_pkg::PROTO_POS)) begin
                n_proto = r_byte;
            end
            if (r_count >= COUNT_BITS'(udpcc_pkg::ADDR_FIRST) &&
                r_count < COUNT_BITS'(ADDR_LAST)) begin
                n_sum = n_sum + (r_count[0] ? {24'd0, r_byte} : {16'd0, r_byte, 8'd0});
            end
            if (r_count >= COUNT_BITS'(n_ihl)) begin
                w_off  = r_count - COUNT_BITS'(n_ihl);
                w_high = ~w_off[0];
                if (w_off < COUNT_BITS'(udpcc_pkg::OFF_DST)) begin
                    n_src = set_half(r_src, r_byte, w_high);
                end else if (w_off < COUNT_BITS'(udpcc_pkg::OFF_LEN)) begin
                    n_dst = set_half(r_dst, r_byte, w_high);
                end else if (w_off < COUNT_BITS'(udpcc_pkg::OFF_CHK)) begin
                    n_len = set_half(r_len, r_byte, w_high);
                end else if (w_off < COUNT_BITS'(udpcc_pkg::UDP_HDR_BYTES)) begin
                    n_chk = set_half(r_chk, r_byte, w_high);
                end else if (16'(w_off) < r_len) begin
                    if (w_high) begin
                        n_pend = r_byte;
                    end else begin
                        n_sum  = n_sum + {16'd0, r_pend, r_byte};
                        n_pend = '0;
                    end
                end
            end
            n_count = r_count + 1'b1;
        end
    end

    always_comb begin
        o_snap.sum        = n_sum;
        o_snap.proto      = n_proto;
        o_snap.ip_udp_len = 16'(n_count) - 16'(n_ihl);
        o_snap.src_port   = n_src;
        o_snap.dst_port   = n_dst;
        o_snap.udp_len    = n_len;
        o_snap.rx_chk     = n_chk;
        o_snap.pending    = n_pend;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_take && r_last)) begin
            r_count <= '0;
            r_ihl   <= '0;
            r_proto <= '0;
            r_sum   <= '0;
            r_pend  <= '0;
            r_len   <= '0;
            r_src   <= '0;
            r_dst   <= '0;
            r_chk   <= '0;
        end else if (w_take) begin
            r_count <= n_count;
            r_ihl   <= n_ihl;
            r_proto <= n_proto;
            r_sum   <= n_sum;
            r_pend  <= n_pend;
            r_len   <= n_len;
            r_src   <= n_src;
            r_dst   <= n_dst;
            r_chk   <= n_chk;
        end
    end

`ifndef NO_ASSERTIONS
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && r_last) |=> (r_count == '0 && r_sum == '0))
        else $error("packet state not cleared after last item");

    a_count_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && !r_last && r_count == COUNT_MAX) |=> (r_count == COUNT_MAX))
        else $error("byte count moved past its maximum");
`endif

endmodule
`default_nettype wire

/* rtl/udpcc_fin.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// udpcc_fin
// Snapshot register, pseudo header and header word sum, end-around fold,
// invert and compare, with the result register on the output side.
// ----------------------------------------------------------------------------
module udpcc_fin (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_snap_valid,
    input  udpcc_pkg::t_snap     i_snap,
    output logic                 o_snap_ready,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output logic [1:0]           o_status,
    output logic [15:0]          o_source_port,
    output logic [15:0]          o_destination_port,
    output logic [15:0]          o_received_checksum,
    output logic [15:0]          o_computed_checksum
);

    localparam int SB = udpcc_pkg::SUM_BITS;

    logic                        r_s_valid;
    udpcc_pkg::t_snap            r_snap;

    logic                        r_f_valid;
    logic [SB-1:0]               r_sum, n_sum;
    logic [15:0]                 r_f_src, r_f_dst, r_f_rx;

    logic                        r_out_valid;
    udpcc_pkg::t_status          r_status, n_status;
    logic [15:0]                 r_src, r_dst, r_rx, r_comp;

    logic [20:0]                 w_t;
    logic [16:0]                 w_u;
    logic [15:0]                 w_v;
    logic [15:0]                 n_comp;

    logic                        w_out_free;
    logic                        w_f_free;

    function automatic logic [15:0] hdr_word(logic [15:0] w, logic [15:0] len, int off);
        logic [15:0] v;
        if (17'(len) >= 17'(off + 2)) begin
            v = w;
        end else if (17'(len) == 17'(off + 1)) begin
            v = {w[15:8], 8'd0};
        end else begin
            v = '0;
        end
        return v;
    endfunction

    assign w_out_free   = !r_out_valid || i_out_ready;
    assign w_f_free     = !r_f_valid || w_out_free;
    assign o_snap_ready = !r_s_valid || w_f_free;

    always_comb begin
        n_sum = SB'(r_snap.sum)
              + SB'(r_snap.proto)
              + SB'(r_snap.ip_udp_len)
              + SB'(hdr_word(r_snap.src_port, r_snap.udp_len, 0))
              + SB'(hdr_word(r_snap.dst_port, r_snap.udp_len, udpcc_pkg::OFF_DST))
              + SB'(hdr_word(r_snap.udp_len, r_snap.udp_len, udpcc_pkg::OFF_LEN))
              + SB'({r_snap.pending, 8'd0});
    end

    always_comb begin
        w_t    = 21'(r_sum[15:0]) + 21'(r_sum[SB-1:16]);
        w_u    = 17'(w_t[15:0]) + 17'(w_t[20:16]);
        w_v    = w_u[15:0] + 16'(w_u[16]);
        n_comp = ~w_v;
        if (r_f_rx == '0) begin
            n_status = udpcc_pkg::ST_DISABLED;
        end else if (r_f_rx != n_comp) begin
            n_status = udpcc_pkg::ST_BAD;
        end else begin
            n_status = udpcc_pkg::ST_GOOD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_valid   <= 1'b0;
            r_f_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_snap_ready) begin
                r_s_valid <= i_snap_valid;
            end
            if (w_f_free) begin
                r_f_valid <= r_s_valid;
            end
            if (w_out_free) begin
                r_out_valid <= r_f_valid;
            end
        end
        if (o_snap_ready && i_snap_valid) begin
            r_snap <= i_snap;
        end
        if (w_f_free && r_s_valid) begin
            r_sum   <= n_sum;
            r_f_src <= r_snap.src_port;
            r_f_dst <= r_snap.dst_port;
            r_f_rx  <= r_snap.rx_chk;
        end
        if (w_out_free && r_f_valid) begin
            r_status <= n_status;
            r_src    <= r_f_src;
            r_dst    <= r_f_dst;
            r_rx     <= r_f_rx;
            r_comp   <= n_comp;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_status            = r_status;
    assign o_source_port       = r_src;
    assign o_destination_port  = r_dst;
    assign o_received_checksum = r_rx;
    assign o_computed_checksum = r_comp;

`ifndef NO_ASSERTIONS
    a_disabled_means_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status == udpcc_pkg::ST_DISABLED) |-> (r_rx == '0))
        else $error("disabled status with nonzero received checksum");

    a_good_means_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status == udpcc_pkg::ST_GOOD) |-> (r_rx == r_comp && r_rx != '0))
        else $error("good status without checksum match");

    a_snap_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s_valid && !w_f_free) |=> (r_s_valid && $stable(r_snap)))
        else $error("stalled snapshot lost or changed");
`endif

endmodule
`default_nettype wire

/* rtl/udp_datagram_checksum_checker_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// udp_datagram_checksum_checker_top
// Checks the UDP checksum of an IPv4 packet fed one byte per item.
// ----------------------------------------------------------------------------
// throughput: one byte item per cycle while o_in_ready is high; a last byte waits
//   while the snapshot register is full and the output side stalls
// path: a last byte passes the input, snapshot, sum and result registers in turn
// reset: synchronous active low; clears all packet state and empties the
//   pipeline, with no clearing pass
// ----------------------------------------------------------------------------
module udp_datagram_checksum_checker_top #(
    parameter int COUNT_BITS    = udpcc_pkg::COUNT_BITS_DEF,
    parameter int ADDRESS_BYTES = udpcc_pkg::ADDRESS_BYTES_DEF
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_in_valid,
    output logic         o_in_ready,
    input  wire  [7:0]   i_data_byte,
    input  wire          i_last_byte,
    output logic         o_out_valid,
    input  wire          i_out_ready,
    output logic [1:0]   o_status,
    output logic [15:0]  o_source_port,
    output logic [15:0]  o_destination_port,
    output logic [15:0]  o_received_checksum,
    output logic [15:0]  o_computed_checksum
);

    logic               w_snap_valid;
    logic               w_snap_ready;
    udpcc_pkg::t_snap   w_snap;

    udpcc_acc #(
        .COUNT_BITS    (COUNT_BITS),
        .ADDRESS_BYTES (ADDRESS_BYTES)
    ) u_acc (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_data_byte  (i_data_byte),
        .i_last_byte  (i_last_byte),
        .o_snap_valid (w_snap_valid),
        .o_snap       (w_snap),
        .i_snap_ready (w_snap_ready)
    );

    udpcc_fin u_fin (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_snap_valid        (w_snap_valid),
        .i_snap              (w_snap),
        .o_snap_ready        (w_snap_ready),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_status            (o_status),
        .o_source_port       (o_source_port),
        .o_destination_port  (o_destination_port),
        .o_received_checksum (o_received_checksum),
        .o_computed_checksum (o_computed_checksum)
    );

endmodule
`default_nettype wire
